>>> hdl/bsmsi_pkg.sv
// ----------------------------------------------------------------------------
// bsmsi_pkg
// Shared types and codes of the bank-switching mapper: transaction payloads,
// register file view and address translation result.
// ----------------------------------------------------------------------------
package bsmsi_pkg;

  localparam int unsigned WORK_RAM_BYTES_DFLT = 8192;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned MADDR_W = 19;

  // Bus event codes.
  localparam logic [1:0] OP_CPU_RD = 2'd0;
  localparam logic [1:0] OP_CPU_WR = 2'd1;
  localparam logic [1:0] OP_PPU_RD = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Target codes.
  localparam logic [1:0] TGT_PRG_ROM = 2'd0;
  localparam logic [1:0] TGT_PRG_RAM = 2'd1;
  localparam logic [1:0] TGT_CHR_ROM = 2'd2;
  localparam logic [1:0] TGT_NONE    = 2'd3;

  // Register windows, addr[15:13].
  localparam logic [2:0] WIN_RAM    = 3'b011;
  localparam logic [2:0] WIN_SELECT = 3'b100;
  localparam logic [2:0] WIN_MIRROR = 3'b101;
  localparam logic [2:0] WIN_IRQCFG = 3'b110;
  localparam logic [2:0] WIN_IRQEN  = 3'b111;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } bsmsi_in_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         target;
    logic [MADDR_W-1:0] mem_offset;
    logic [7:0]         read_data;
    logic               irq_line;
    logic               mirror_mode;
  } bsmsi_out_t;

  typedef struct packed {
    logic [7:0][7:0] bank;
    logic            prg_swap_mode;
    logic            chr_invert;
    logic [5:0]      prg_bank_count;
  } bsmsi_regs_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         target;
    logic [MADDR_W-1:0] mem_offset;
  } bsmsi_map_t;

endpackage

>>> hdl/bank_switch_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq
// Cartridge bank-switching mapper with work RAM and scanline interrupt.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one bus event per
// transaction: a CPU read or write, a PPU read or a scanline tick. The output
// channel (out_valid, out_ready, out_data) returns one result per event, in
// order: hit, target, mapped offset, work RAM read data, and the interrupt
// line and mirroring as they stand after the event.
// cfg_wr_en/cfg_wr_data set the number of 16 KiB program banks while idle.
// An accepted event is registered in the second stage and moves to the output
// register, which drives out_valid, once that register is free. One event is
// accepted every cycle unless the receiver stalls; the work RAM is a single-port
// synchronous memory read or written once per event that addresses it, and its
// registered read data joins the result in the second stage. Registers and
// counters change at acceptance, so each event sees the effect of all before it.
// When the receiver stalls, the output register holds its result and the
// second stage holds the next; in_ready drops only when both are full.
// Reset restores the power-on bank registers, horizontal mirroring, a bank
// count of one and a cleared interrupt; the work RAM is not cleared.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq import bsmsi_pkg::*; #(
  parameter int unsigned WORK_RAM_BYTES = WORK_RAM_BYTES_DFLT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  bsmsi_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bsmsi_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  localparam int unsigned RAM_AW = $clog2(WORK_RAM_BYTES);

  logic [7:0][7:0] bank_r;
  logic [2:0]      reg_sel_r;
  logic            prg_mode_r, chr_inv_r, mirror_r;
  logic [7:0]      irq_reload_r, irq_count_r;
  logic            irq_en_r, irq_pend_r;
  logic [5:0]      prg_cnt_r;

  logic [7:0]      irq_count_nxt;
  logic            irq_en_nxt, irq_pend_nxt, mirror_nxt;

  bsmsi_regs_t       regs;
  bsmsi_map_t        map;
  logic [RAM_AW-1:0] ram_idx;

  logic [7:0] ram [WORK_RAM_BYTES];
  logic [7:0] ram_q_r;

  bsmsi_map_t s1_map_r;
  logic       s1_v_r, s1_rd_r, s1_irq_r, s1_mirror_r;
  logic       out_v_r;
  bsmsi_out_t out_r;

  logic in_acc, s1_adv, ram_sel, wr_reg;

  assign regs.bank           = bank_r;
  assign regs.prg_swap_mode  = prg_mode_r;
  assign regs.chr_invert     = chr_inv_r;
  assign regs.prg_bank_count = prg_cnt_r;

  bsmsi_xlat #(
    .WORK_RAM_BYTES (WORK_RAM_BYTES),
    .RAM_AW         (RAM_AW)
  ) u_xlat (
    .req     (in_data),
    .regs    (regs),
    .map     (map),
    .ram_idx (ram_idx)
  );

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign ram_sel  = (in_data.op == OP_CPU_RD || in_data.op == OP_CPU_WR) &&
                    (in_data.addr[15:13] == WIN_RAM);
  assign wr_reg   = in_acc && (in_data.op == OP_CPU_WR) && in_data.addr[15];

  // Interrupt and mirroring as they stand after the current event.
  always_comb begin
    irq_count_nxt = irq_count_r;
    irq_en_nxt    = irq_en_r;
    irq_pend_nxt  = irq_pend_r;
    mirror_nxt    = mirror_r;
    if (in_data.op == OP_TICK) begin
      irq_count_nxt = (irq_count_r == 8'd0) ? irq_reload_r : irq_count_r - 8'd1;
      if (irq_count_nxt == 8'd0 && irq_en_r) begin
        irq_pend_nxt = 1'b1;
      end
    end else if (in_data.op == OP_CPU_WR && in_data.addr[15]) begin
      unique case (in_data.addr[15:13])
        WIN_MIRROR: begin
          if (!in_data.addr[0]) begin
            mirror_nxt = in_data.data[0];
          end
        end
        WIN_IRQCFG: begin
          if (in_data.addr[0]) begin
            irq_count_nxt = 8'd0;
          end
        end
        WIN_IRQEN: begin
          if (in_data.addr[0]) begin
            irq_en_nxt = 1'b1;
          end else begin
            irq_en_nxt   = 1'b0;
            irq_pend_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r       <= {8'd1, 56'd0};
      reg_sel_r    <= 3'd0;
      prg_mode_r   <= 1'b0;
      chr_inv_r    <= 1'b0;
      mirror_r     <= 1'b1;
      irq_reload_r <= 8'd0;
      irq_count_r  <= 8'd0;
      irq_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
      prg_cnt_r    <= 6'd1;
    end else begin
      if (cfg_wr_en) begin
        prg_cnt_r <= cfg_wr_data;
      end
      if (in_acc) begin
        mirror_r    <= mirror_nxt;
        irq_count_r <= irq_count_nxt;
        irq_en_r    <= irq_en_nxt;
        irq_pend_r  <= irq_pend_nxt;
      end
      if (wr_reg && in_data.addr[15:13] == WIN_SELECT) begin
        if (in_data.addr[0]) begin
          bank_r[reg_sel_r] <= in_data.data;
        end else begin
          reg_sel_r  <= in_data.data[2:0];
          prg_mode_r <= in_data.data[6];
          chr_inv_r  <= in_data.data[7];
        end
      end
      if (wr_reg && in_data.addr[15:13] == WIN_IRQCFG && !in_data.addr[0]) begin
        irq_reload_r <= in_data.data;
      end
    end
  end

  // Work RAM: one access per work RAM transaction. The read data register only loads
  // on a read, so it holds while the second stage is stalled.
  always_ff @(posedge clk) begin
    if (in_acc && ram_sel) begin
      if (in_data.op == OP_CPU_WR) begin
        ram[ram_idx] <= in_data.data;
      end else begin
        ram_q_r <= ram[ram_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_map_r    <= map;
      s1_rd_r     <= ram_sel && (in_data.op == OP_CPU_RD);
      s1_irq_r    <= irq_pend_nxt;
      s1_mirror_r <= mirror_nxt;
    end
    if (s1_adv && s1_v_r) begin
      out_r.hit         <= s1_map_r.hit;
      out_r.target      <= s1_map_r.target;
      out_r.mem_offset  <= s1_map_r.mem_offset;
      out_r.read_data   <= s1_rd_r ? ram_q_r : 8'd0;
      out_r.irq_line    <= s1_irq_r;
      out_r.mirror_mode <= s1_mirror_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

  a_pending_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    irq_pend_r |-> irq_en_r)
    else $error("interrupt pending while disabled");

  a_read_data_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.target != TGT_PRG_RAM) |-> (out_r.read_data == 8'd0))
    else $error("read data outside work RAM result");

  a_miss_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.hit) |-> (out_r.target == TGT_NONE && out_r.mem_offset == '0))
    else $error("unmapped result carries a target or offset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv && !in_acc) |=> out_v_r)
    else $error("second stage result lost on advance");

endmodule

>>> hdl/bsmsi_xlat.sv
// ----------------------------------------------------------------------------
// bsmsi_xlat
// Address translation: decodes one bus event against the live bank registers
// into hit, target and byte offset, and forms the work RAM index.
// ----------------------------------------------------------------------------
module bsmsi_xlat import bsmsi_pkg::*; #(
  parameter int unsigned WORK_RAM_BYTES = WORK_RAM_BYTES_DFLT,
  parameter int unsigned RAM_AW         = $clog2(WORK_RAM_BYTES)
) (
  input  bsmsi_in_t          req,
  input  bsmsi_regs_t        regs,
  output bsmsi_map_t         map,
  output logic [RAM_AW-1:0]  ram_idx
);

  localparam logic [15:0] MOD1 = 16'(WORK_RAM_BYTES);
  localparam logic [15:0] MOD2 = 16'(2 * WORK_RAM_BYTES);
  localparam logic [15:0] MOD4 = 16'(4 * WORK_RAM_BYTES);

  logic [15:0] red0, red1, red2, red3;
  logic [5:0]  dbl, last_bank, second_bank, prg_bank;
  logic [1:0]  slot;
  logic [2:0]  half;
  logic [7:0]  chr_bank, chr_pair;

  // The offset is below 8192 and the size at least 1024, so three
  // conditional subtractions bring it below the RAM size.
  always_comb begin
    red0 = {3'b000, req.addr[12:0]};
    red1 = (red0 >= MOD4) ? red0 - MOD4 : red0;
    red2 = (red1 >= MOD2) ? red1 - MOD2 : red1;
    red3 = (red2 >= MOD1) ? red2 - MOD1 : red2;
  end
  assign ram_idx = red3[RAM_AW-1:0];

  always_comb begin
    dbl         = {regs.prg_bank_count[4:0], 1'b0};
    last_bank   = dbl - 6'd1;
    second_bank = dbl - 6'd2;
    slot        = req.addr[14:13];
    if (slot == 2'd1) begin
      prg_bank = regs.bank[7][5:0];
    end else if (slot == 2'd3) begin
      prg_bank = last_bank;
    end else if ((slot == 2'd0) == !regs.prg_swap_mode) begin
      prg_bank = regs.bank[6][5:0];
    end else begin
      prg_bank = second_bank;
    end
  end

  always_comb begin
    half     = req.addr[12:10] ^ {regs.chr_invert, 2'b00};
    chr_pair = regs.bank[{2'b00, half[1]}];
    if (!half[2]) begin
      chr_bank = {chr_pair[7:1], half[0]};
    end else begin
      chr_bank = regs.bank[half - 3'd2];
    end
  end

  always_comb begin
    map.hit        = 1'b0;
    map.target     = TGT_NONE;
    map.mem_offset = '0;
    unique case (req.op) inside
      OP_CPU_RD, OP_CPU_WR: begin
        if (req.addr[15:13] == WIN_RAM) begin
          map.hit        = 1'b1;
          map.target     = TGT_PRG_RAM;
          map.mem_offset = {6'd0, red3[12:0]};
        end else if (req.addr[15]) begin
          map.hit = 1'b1;
          if (req.op == OP_CPU_RD) begin
            map.target     = TGT_PRG_ROM;
            map.mem_offset = {prg_bank, req.addr[12:0]};
          end
        end
      end
      OP_PPU_RD: begin
        if (req.addr[15:13] == 3'b000) begin
          map.hit        = 1'b1;
          map.target     = TGT_CHR_ROM;
          map.mem_offset = {1'b0, chr_bank, req.addr[9:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> dv/bank_switch_mapper_with_scanline_irq_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq_tb
// Self-checking bench for the cartridge mapper. A directed table covers the
// power-on mapping, the address extremes, every register window and the
// scanline interrupt. Random bus traffic then runs under several program bank
// counts. Results are checked against the table or a cycle-free predictor,
// and both channels idle and stall at random but in one steady phase.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq_tb;
  import bsmsi_pkg::*;

  localparam int unsigned RAM_BYTES       = WORK_RAM_BYTES_DFLT;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned PHASES          = 6;

  typedef struct {
    bsmsi_in_t  ev;
    bit         typed;
    bsmsi_out_t want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  bsmsi_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  bsmsi_out_t out_data;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;

  // Predicted mapper state.
  logic [7:0]  bank_q [8];
  logic [2:0]  sel_q;
  logic        swap_q;
  logic        inv_q;
  logic        mirror_q;
  logic [7:0]  reload_q;
  logic [7:0]  count_q;
  logic        irq_en_q;
  logic        irq_pend_q;
  logic [5:0]  bank_count_q;
  logic [7:0]  ram_q [RAM_BYTES];
  bit          ram_written [RAM_BYTES];
  int unsigned written_idx [$];

  bsmsi_out_t  mapped_results_q [$];
  dir_row_t    dir_rows [$];
  bit          steady_flow;
  int unsigned mismatch_count;
  int unsigned stuck_cycles;
  int unsigned stall_left;
  int unsigned stall_len;
  bsmsi_out_t  head;

  bank_switch_mapper_with_scanline_irq u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one bus access to the predicted state and returns its result.
  function automatic bsmsi_out_t predict_access(input bsmsi_in_t ev);
    bsmsi_out_t r;
    logic [12:0] ri;
    logic [1:0]  slot;
    logic [2:0]  half;
    logic [5:0]  pbank;
    logic [7:0]  cbank;
    r = '0;
    r.target = TGT_NONE;
    ri = 13'(ev.addr[12:0] % RAM_BYTES);
    case (ev.op) inside
      OP_CPU_RD, OP_CPU_WR: begin
        if (ev.addr[15:13] == WIN_RAM) begin
          r.hit = 1'b1;
          r.target = TGT_PRG_RAM;
          r.mem_offset = 19'(ri);
          if (ev.op == OP_CPU_RD) begin
            r.read_data = ram_q[ri];
          end else begin
            ram_q[ri] = ev.data;
            if (!ram_written[ri]) begin
              ram_written[ri] = 1'b1;
              written_idx.push_back(32'(ri));
            end
          end
        end else if (ev.addr[15]) begin
          r.hit = 1'b1;
          if (ev.op == OP_CPU_RD) begin
            // The two fixed banks are the last two 8 KiB banks, modulo 64.
            slot = ev.addr[14:13];
            if (slot == 2'd1) pbank = bank_q[7][5:0];
            else if (slot == 2'd3) pbank = {bank_count_q[4:0], 1'b0} - 6'd1;
            else if ((slot == 2'd0) == !swap_q) pbank = bank_q[6][5:0];
            else pbank = {bank_count_q[4:0], 1'b0} - 6'd2;
            r.target = TGT_PRG_ROM;
            r.mem_offset = {pbank, ev.addr[12:0]};
          end else begin
            case (ev.addr[15:13])
              WIN_SELECT: begin
                if (!ev.addr[0]) begin
                  sel_q = ev.data[2:0];
                  swap_q = ev.data[6];
                  inv_q = ev.data[7];
                end else begin
                  bank_q[sel_q] = ev.data;
                end
              end
              // The odd address here is the RAM protect register, which is ignored.
              WIN_MIRROR: if (!ev.addr[0]) mirror_q = ev.data[0];
              WIN_IRQCFG: begin
                if (!ev.addr[0]) reload_q = ev.data;
                else count_q = '0;
              end
              default: begin
                if (!ev.addr[0]) begin
                  irq_en_q = 1'b0;
                  irq_pend_q = 1'b0;
                end else begin
                  irq_en_q = 1'b1;
                end
              end
            endcase
          end
        end
      end
      OP_PPU_RD: begin
        if (ev.addr <= 16'h1FFF) begin
          half = ev.addr[12:10] ^ {inv_q, 2'b00};
          if (!half[2]) begin
            cbank = half[0] ? (bank_q[{2'b00, half[1]}] | 8'h01)
                            : (bank_q[{2'b00, half[1]}] & 8'hFE);
          end else begin
            cbank = bank_q[half - 3'd2];
          end
          r.hit = 1'b1;
          r.target = TGT_CHR_ROM;
          r.mem_offset = {1'b0, cbank, ev.addr[9:0]};
        end
      end
      default: begin
        if (count_q == 8'd0) count_q = reload_q;
        else count_q = count_q - 8'd1;
        if (count_q == 8'd0 && irq_en_q) irq_pend_q = 1'b1;
      end
    endcase
    r.irq_line = irq_pend_q;
    r.mirror_mode = mirror_q;
    return r;
  endfunction

  // Mostly well-formed traffic; work RAM reads only hit bytes already written.
  function automatic bsmsi_in_t random_access();
    bsmsi_in_t ev;
    int unsigned pick;
    ev.op = OP_CPU_RD;
    ev.addr = 16'($urandom());
    ev.data = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      ev.addr[15] = 1'b1;
    end else if (pick < 30 && written_idx.size() > 0) begin
      ev.addr = 16'h6000 | 16'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
    end else if (pick < 40) begin
      ev.op = OP_CPU_WR;
      ev.addr[15:13] = WIN_RAM;
    end else if (pick < 62) begin
      ev.op = OP_CPU_WR;
      ev.addr[15:13] = 3'($urandom_range(4, 7));
      // Small reload values let the counter reach zero often.
      if (ev.addr[15:13] == WIN_IRQCFG && $urandom_range(0, 3) != 0)
        ev.data = 8'($urandom_range(0, 7));
    end else if (pick < 80) begin
      ev.op = OP_PPU_RD;
      if ($urandom_range(0, 7) != 0) ev.addr[15:13] = 3'b000;
    end else if (pick < 92) begin
      ev.op = OP_TICK;
    end else begin
      ev.op = $urandom_range(0, 1) ? OP_CPU_WR : OP_CPU_RD;
      ev.addr = 16'($urandom_range(0, 16'h5FFF));
    end
    return ev;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d,
                         input bit typed, input bsmsi_out_t want);
    dir_row_t row;
    row.ev = {op, a, d};
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_access(input bsmsi_in_t ev, input bit typed, input bsmsi_out_t want);
    int unsigned gap;
    bsmsi_out_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    predicted = predict_access(ev);
    mapped_results_q.push_back(typed ? want : predicted);
  endtask

  task automatic program_bank_count(input logic [5:0] count);
    while (mapped_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bank_count_q = count;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_len = pick_gap();
      out_ready <= (stall_len == 0);
      if (stall_len > 0) stall_left <= stall_len - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mapped_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result: hit=%0d tgt=%0d addr=%05h rd=%02h irq=%0d mir=%0d",
                   $time, out_data.hit, out_data.target, out_data.mem_offset,
                   out_data.read_data, out_data.irq_line, out_data.mirror_mode);
      end else begin
        head = mapped_results_q.pop_front();
        if (out_data.hit !== head.hit || out_data.target !== head.target ||
            out_data.mem_offset !== head.mem_offset || out_data.read_data !== head.read_data ||
            out_data.irq_line !== head.irq_line || out_data.mirror_mode !== head.mirror_mode) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected hit=%0d tgt=%0d addr=%05h rd=%02h irq=%0d mir=%0d",
                     $time, head.hit, head.target, head.mem_offset,
                     head.read_data, head.irq_line, head.mirror_mode);
            $display("%0t: actual   hit=%0d tgt=%0d addr=%05h rd=%02h irq=%0d mir=%0d",
                     $time, out_data.hit, out_data.target, out_data.mem_offset,
                     out_data.read_data, out_data.irq_line, out_data.mirror_mode);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("bank_switch_mapper_with_scanline_irq_tb failed");
      $finish;
    end
  end

  initial begin
    logic [5:0] count;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    steady_flow = 1'b0;
    mismatch_count = 0;
    stuck_cycles = 0;
    stall_left = 0;

    foreach (bank_q[i]) bank_q[i] = 8'h00;
    bank_q[7] = 8'h01;
    sel_q = '0;
    swap_q = 1'b0;
    inv_q = 1'b0;
    mirror_q = 1'b1;
    reload_q = '0;
    count_q = '0;
    irq_en_q = 1'b0;
    irq_pend_q = 1'b0;
    bank_count_q = 6'd1;
    foreach (ram_written[i]) ram_written[i] = 1'b0;

    // Power-on mapping with one 16 KiB bank: R6 = 0, R7 = 1, fixed banks 0 and 1.
    add_row(OP_CPU_RD, 16'h8000, 8'h00, 1, {1'b1, TGT_PRG_ROM, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_RD, 16'hA001, 8'h00, 1, {1'b1, TGT_PRG_ROM, 19'h02001, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_RD, 16'hFFFF, 8'hFF, 1, {1'b1, TGT_PRG_ROM, 19'h03FFF, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_RD, 16'h0000, 8'h00, 1, {1'b0, TGT_NONE, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_PPU_RD, 16'h0000, 8'h00, 1, {1'b1, TGT_CHR_ROM, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_PPU_RD, 16'h1FFF, 8'h00, 1, {1'b1, TGT_CHR_ROM, 19'h003FF, 8'h00, 1'b0, 1'b1});
    add_row(OP_PPU_RD, 16'h2000, 8'h00, 1, {1'b0, TGT_NONE, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_PPU_RD, 16'hFFFF, 8'hFF, 1, {1'b0, TGT_NONE, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_WR, 16'h6000, 8'hA5, 1, {1'b1, TGT_PRG_RAM, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_WR, 16'h7FFF, 8'h5A, 1, {1'b1, TGT_PRG_RAM, 19'h01FFF, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_RD, 16'h6000, 8'h00, 1, {1'b1, TGT_PRG_RAM, 19'h00000, 8'hA5, 1'b0, 1'b1});
    add_row(OP_CPU_RD, 16'h7FFF, 8'h00, 1, {1'b1, TGT_PRG_RAM, 19'h01FFF, 8'h5A, 1'b0, 1'b1});
    add_row(OP_CPU_WR, 16'h5FFF, 8'hFF, 1, {1'b0, TGT_NONE, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_TICK,   16'hFFFF, 8'hFF, 1, {1'b0, TGT_NONE, 19'h00000, 8'h00, 1'b0, 1'b1});
    add_row(OP_CPU_WR, 16'hA000, 8'h00, 1, {1'b1, TGT_NONE, 19'h00000, 8'h00, 1'b0, 1'b0});
    add_row(OP_CPU_WR, 16'hA001, 8'hFF, 0, '0);
    add_row(OP_CPU_WR, 16'h8000, 8'hC7, 0, '0);
    add_row(OP_CPU_WR, 16'h8001, 8'hFF, 0, '0);
    add_row(OP_CPU_RD, 16'hBFFF, 8'h00, 1, {1'b1, TGT_PRG_ROM, 19'h7FFFF, 8'h00, 1'b0, 1'b0});
    add_row(OP_PPU_RD, 16'h0400, 8'h00, 0, '0);
    add_row(OP_CPU_WR, 16'hC000, 8'h02, 0, '0);
    add_row(OP_CPU_WR, 16'hE001, 8'h00, 0, '0);
    add_row(OP_TICK,   16'h0000, 8'h00, 0, '0);
    add_row(OP_TICK,   16'h0000, 8'h00, 0, '0);
    add_row(OP_TICK,   16'h0000, 8'h00, 0, '0);
    add_row(OP_CPU_WR, 16'hC001, 8'h00, 0, '0);
    add_row(OP_CPU_WR, 16'hE000, 8'h00, 0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_bank_count(6'd1);
    foreach (dir_rows[i]) send_access(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    in_valid <= 1'b0;

    // Bank counts include the range ends and the 6-bit wrap cases.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: count = 6'd32;
        1: count = 6'd0;
        2: count = 6'd63;
        3: count = 6'd2;
        default: count = 6'($urandom_range(1, 32));
      endcase
      steady_flow = (ph == 2);
      program_bank_count(count);
      repeat (ITEMS_PER_PHASE) send_access(random_access(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    while (mapped_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bank_switch_mapper_with_scanline_irq_tb passed");
    end else begin
      $display("bank_switch_mapper_with_scanline_irq_tb failed");
    end
    $finish;
  end

endmodule
